### src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, register indexes and timing defaults for the power
// sequencing controller.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Default timing figures in milliseconds
  localparam int unsigned PulseMsDefault    = 3200;
  localparam int unsigned RecoveryMsDefault = 2000;
  localparam int unsigned BackupMsDefault   = 24000;

  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_POWER_ON_TH   = 3'd0,
    CFG_POWER_FAIL_TH = 3'd1,
    CFG_IGNITION_TH   = 3'd2,
    CFG_START_TMIN    = 3'd3,
    CFG_START_TMAX    = 3'd4,
    CFG_RUN_TMIN      = 3'd5,
    CFG_RUN_TMAX      = 3'd6
  } psc_cfg_idx_t;

  // Operating modes
  typedef enum logic [2:0] {
    MODE_OFF         = 3'd0,
    MODE_TURNING_ON  = 3'd1,
    MODE_ON          = 3'd2,
    MODE_RECOVERY    = 3'd3,
    MODE_BACKUP      = 3'd4,
    MODE_TURNING_OFF = 3'd5
  } psc_mode_t;

  // Shutdown request kinds
  typedef enum logic [1:0] {
    SHDN_NONE = 2'd0,
    SHDN_HOST = 2'd1,
    SHDN_CUT  = 2'd2
  } psc_shdn_t;

  // LED colors
  typedef enum logic [1:0] {
    LED_KEEP   = 2'd0,
    LED_GREEN  = 2'd1,
    LED_BLUE   = 2'd2,
    LED_YELLOW = 2'd3
  } psc_led_t;

  // Register file contents
  typedef struct packed {
    logic [15:0] power_on_threshold;
    logic [15:0] power_fail_threshold;
    logic [15:0] ignition_threshold;
    logic [15:0] start_temp_min;
    logic [15:0] start_temp_max;
    logic [15:0] run_temp_min;
    logic [15:0] run_temp_max;
  } psc_cfg_t;

  // One input item
  typedef struct packed {
    logic [9:0]  tick_ms;
    logic [15:0] supply_level;
    logic [15:0] ignition_level;
    logic [15:0] temp_reading;
    logic        motion_wake;
    logic        lockup_wake;
    logic        watchdog_wake;
    logic        alarm_wake;
    logic        host_up;
    logic        host_down;
  } psc_in_t;

  // One result item
  typedef struct packed {
    logic [2:0] mode_now;
    logic       button_pulse;
    logic [1:0] shutdown_kind;
    logic [1:0] led_colour;
    logic       power_loss_pulse;
    logic       powered_up;
    logic [4:0] wake_reasons;
  } psc_out_t;

endpackage

### src/psc_if.sv
// ----------------------------------------------------------------------------
// psc_if
// Valid/ready channel interfaces: tick input, result output, config write.
// ----------------------------------------------------------------------------
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  tick_ms;
  logic [15:0] supply_level;
  logic [15:0] ignition_level;
  logic [15:0] temp_reading;
  logic        motion_wake;
  logic        lockup_wake;
  logic        watchdog_wake;
  logic        alarm_wake;
  logic        host_up;
  logic        host_down;

  modport source (output valid, tick_ms, supply_level, ignition_level, temp_reading,
                  motion_wake, lockup_wake, watchdog_wake, alarm_wake, host_up,
                  host_down, input ready);
  modport sink   (input valid, tick_ms, supply_level, ignition_level, temp_reading,
                  motion_wake, lockup_wake, watchdog_wake, alarm_wake, host_up,
                  host_down, output ready);
endinterface

interface psc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode_now;
  logic       button_pulse;
  logic [1:0] shutdown_kind;
  logic [1:0] led_colour;
  logic       power_loss_pulse;
  logic       powered_up;
  logic [4:0] wake_reasons;

  modport source (output valid, mode_now, button_pulse, shutdown_kind, led_colour,
                  power_loss_pulse, powered_up, wake_reasons, input ready);
  modport sink   (input valid, mode_now, button_pulse, shutdown_kind, led_colour,
                  power_loss_pulse, powered_up, wake_reasons, output ready);
endinterface

interface psc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [psc_pkg::CfgIdxW-1:0]    index;
  logic [15:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/psc_cfg_regs.sv
// ----------------------------------------------------------------------------
// psc_cfg_regs
// Threshold and temperature window registers written over the config channel.
// ----------------------------------------------------------------------------
module psc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [psc_pkg::CfgIdxW-1:0] wr_idx,
  input  logic [15:0]                 wr_data,
  output psc_pkg::psc_cfg_t           cfg
);

  psc_pkg::psc_cfg_t cfg_r;

  // Register write, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_on_threshold   <= 16'd0;
      cfg_r.power_fail_threshold <= 16'd0;
      cfg_r.ignition_threshold   <= 16'd0;
      cfg_r.start_temp_min       <= 16'd0;
      cfg_r.start_temp_max       <= 16'hFFFF;
      cfg_r.run_temp_min         <= 16'd0;
      cfg_r.run_temp_max         <= 16'hFFFF;
    end else if (wr_en) begin
      case (wr_idx)
        psc_pkg::CFG_POWER_ON_TH:   cfg_r.power_on_threshold   <= wr_data;
        psc_pkg::CFG_POWER_FAIL_TH: cfg_r.power_fail_threshold <= wr_data;
        psc_pkg::CFG_IGNITION_TH:   cfg_r.ignition_threshold   <= wr_data;
        psc_pkg::CFG_START_TMIN:    cfg_r.start_temp_min       <= wr_data;
        psc_pkg::CFG_START_TMAX:    cfg_r.start_temp_max       <= wr_data;
        psc_pkg::CFG_RUN_TMIN:      cfg_r.run_temp_min         <= wr_data;
        psc_pkg::CFG_RUN_TMAX:      cfg_r.run_temp_max         <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/psc_core.sv
// ----------------------------------------------------------------------------
// psc_core
// Mode state machine, wake reason mask, backup timer and button pulse timer.
// State advances on every accepted item; the result is combinational.
// ----------------------------------------------------------------------------
module psc_core #(
  parameter int unsigned PULSE_MS    = psc_pkg::PulseMsDefault,
  parameter int unsigned RECOVERY_MS = psc_pkg::RecoveryMsDefault,
  parameter int unsigned BACKUP_MS   = psc_pkg::BackupMsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  psc_pkg::psc_in_t  item,
  input  psc_pkg::psc_cfg_t cfg,
  output psc_pkg::psc_out_t result
);

  localparam logic [15:0] PulseLim    = 16'(PULSE_MS);
  localparam logic [15:0] RecoveryLim = 16'(RECOVERY_MS);
  localparam logic [15:0] BackupLim   = 16'(BACKUP_MS);

  psc_pkg::psc_mode_t mode_r, mode_nxt;
  logic [15:0]        backup_r, backup_nxt;
  logic               pulse_en_r, pulse_en_nxt;
  logic               pulse_act_r, pulse_act_nxt;
  logic [15:0]        pulse_el_r, pulse_el_nxt;
  logic [4:0]         reason_r, reason_nxt;

  // pulse pre-step results
  logic        p_en, p_act;
  logic [15:0] p_el;
  logic [16:0] p_sum, b_sum;
  logic [15:0] b_sat;

  // state after the mode logic, before shutdown clearing
  psc_pkg::psc_mode_t mode_pre;
  logic [15:0]        backup_pre;
  logic               pen_pre;
  logic [15:0]        pel_pre;
  logic [4:0]         reason_pre;

  psc_pkg::psc_shdn_t kind;
  psc_pkg::psc_led_t  led;
  logic               loss, pwr_up;

  logic supply_lt_fail, supply_ge_on, start_ok, run_ok;

  assign supply_lt_fail = item.supply_level < cfg.power_fail_threshold;
  assign supply_ge_on   = item.supply_level >= cfg.power_on_threshold;
  assign start_ok = (item.temp_reading >= cfg.start_temp_min) &&
                    (item.temp_reading <= cfg.start_temp_max);
  assign run_ok   = (item.temp_reading >= cfg.run_temp_min) &&
                    (item.temp_reading <= cfg.run_temp_max);

  // Saturating timer adds
  assign p_sum = {1'b0, pulse_el_r} + {7'd0, item.tick_ms};
  assign b_sum = {1'b0, backup_r} + {7'd0, item.tick_ms};
  assign b_sat = b_sum[16] ? 16'hFFFF : b_sum[15:0];

  // Button pulse timing, ahead of the mode logic
  always_comb begin
    p_en  = pulse_en_r;
    p_act = pulse_act_r;
    p_el  = pulse_el_r;
    if (pulse_en_r) begin
      if (pulse_el_r < PulseLim) begin
        p_act = 1'b1;
        p_el  = p_sum[16] ? 16'hFFFF : p_sum[15:0];
      end else begin
        p_act = 1'b0;
        p_el  = 16'd0;
        p_en  = 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    mode_pre   = mode_r;
    backup_pre = backup_r;
    pen_pre    = p_en;
    pel_pre    = p_el;
    reason_pre = reason_r;
    if (!item.host_down) begin
      case (mode_r)
        psc_pkg::MODE_OFF: begin
          reason_pre = 5'd0;
          if (supply_ge_on && start_ok) begin
            reason_pre = {item.alarm_wake, item.watchdog_wake, item.lockup_wake,
                          item.motion_wake,
                          item.ignition_level >= cfg.ignition_threshold};
            if (reason_pre != 5'd0) mode_pre = psc_pkg::MODE_TURNING_ON;
          end
        end
        psc_pkg::MODE_TURNING_ON: begin
          if (!supply_lt_fail && !p_act) begin
            pen_pre  = 1'b1;
            pel_pre  = 16'd0;
            mode_pre = psc_pkg::MODE_ON;
          end
        end
        psc_pkg::MODE_ON: begin
          if (supply_lt_fail) mode_pre = psc_pkg::MODE_RECOVERY;
        end
        psc_pkg::MODE_RECOVERY: begin
          backup_pre = b_sat;
          if (b_sat > RecoveryLim) begin
            mode_pre = psc_pkg::MODE_BACKUP;
          end else if (item.host_up && supply_ge_on) begin
            backup_pre = 16'd0;
            mode_pre   = psc_pkg::MODE_ON;
          end
        end
        psc_pkg::MODE_BACKUP: begin
          if (item.host_up) begin
            backup_pre = b_sat;
            if (b_sat > BackupLim) begin
              backup_pre = 16'd0;
              pen_pre    = 1'b1;
              pel_pre    = 16'd0;
              mode_pre   = psc_pkg::MODE_TURNING_OFF;
            end
          end
        end
        psc_pkg::MODE_TURNING_OFF: ;
        default: mode_pre = psc_pkg::MODE_OFF;
      endcase
    end
  end

  // Outputs of the mode logic
  always_comb begin
    kind   = psc_pkg::SHDN_NONE;
    led    = psc_pkg::LED_KEEP;
    loss   = 1'b0;
    pwr_up = 1'b0;
    if (item.host_down) begin
      kind = psc_pkg::SHDN_CUT;
    end else begin
      case (mode_r)
        psc_pkg::MODE_TURNING_ON: begin
          if (supply_lt_fail) begin
            kind = psc_pkg::SHDN_CUT;
          end else if (!p_act) begin
            led    = psc_pkg::LED_GREEN;
            pwr_up = 1'b1;
          end
        end
        psc_pkg::MODE_ON: begin
          if (supply_lt_fail) led = psc_pkg::LED_BLUE;
          else if (!run_ok)   kind = psc_pkg::SHDN_HOST;
        end
        psc_pkg::MODE_RECOVERY: begin
          if (b_sat > RecoveryLim) begin
            loss = 1'b1;
            led  = psc_pkg::LED_YELLOW;
          end else if (!item.host_up) begin
            kind = psc_pkg::SHDN_CUT;
          end else if (supply_ge_on) begin
            led = psc_pkg::LED_GREEN;
          end
        end
        psc_pkg::MODE_BACKUP: begin
          if (!item.host_up) kind = psc_pkg::SHDN_CUT;
        end
        psc_pkg::MODE_TURNING_OFF: kind = psc_pkg::SHDN_HOST;
        default: ;
      endcase
    end
    // a shutdown request shows no colour
    if (kind != psc_pkg::SHDN_NONE) led = psc_pkg::LED_KEEP;
  end

  // Shutdown request returns all state to reset values
  always_comb begin
    if (kind != psc_pkg::SHDN_NONE) begin
      mode_nxt      = psc_pkg::MODE_OFF;
      backup_nxt    = 16'd0;
      pulse_en_nxt  = 1'b0;
      pulse_act_nxt = 1'b0;
      pulse_el_nxt  = 16'd0;
      reason_nxt    = 5'd0;
    end else begin
      mode_nxt      = mode_pre;
      backup_nxt    = backup_pre;
      pulse_en_nxt  = pen_pre;
      pulse_act_nxt = p_act;
      pulse_el_nxt  = pel_pre;
      reason_nxt    = reason_pre;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= psc_pkg::MODE_OFF;
      backup_r    <= 16'd0;
      pulse_en_r  <= 1'b0;
      pulse_act_r <= 1'b0;
      pulse_el_r  <= 16'd0;
      reason_r    <= 5'd0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      backup_r    <= backup_nxt;
      pulse_en_r  <= pulse_en_nxt;
      pulse_act_r <= pulse_act_nxt;
      pulse_el_r  <= pulse_el_nxt;
      reason_r    <= reason_nxt;
    end
  end

  // Result item
  assign result.mode_now         = mode_nxt;
  assign result.button_pulse     = pulse_act_nxt;
  assign result.shutdown_kind    = kind;
  assign result.led_colour       = led;
  assign result.power_loss_pulse = loss;
  assign result.powered_up       = pwr_up;
  assign result.wake_reasons     = reason_nxt;

endmodule

### src/power_sequencing_controller.sv
// An accepted tick item's result is registered and valid in the next cycle.
// Throughput: one item per cycle; the single output register is refilled in
//   the cycle it is drained, so only a stalled consumer holds off input.
// Reset (rst_n low, synchronous): mode off, timers and reason mask cleared,
//   thresholds and temperature windows back to defaults, output empty.
// ----------------------------------------------------------------------------
// power_sequencing_controller
// Top level: config registers, state machine core and the result register.
// ----------------------------------------------------------------------------
module power_sequencing_controller #(
  parameter int unsigned PULSE_MS    = psc_pkg::PulseMsDefault,
  parameter int unsigned RECOVERY_MS = psc_pkg::RecoveryMsDefault,
  parameter int unsigned BACKUP_MS   = psc_pkg::BackupMsDefault
) (
  input logic       clk,
  input logic       rst_n,
  psc_in_if.sink    in_ch,
  psc_out_if.source out_ch,
  psc_cfg_if.sink   cfg_ch
);

  psc_pkg::psc_cfg_t cfg;
  psc_pkg::psc_in_t  item;
  psc_pkg::psc_out_t result;
  psc_pkg::psc_out_t out_r;
  logic              out_valid_r;
  logic              in_ready;
  logic              step;

  // Config channel is always ready
  assign cfg_ch.ready = 1'b1;

  psc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  // Input item gathering
  assign item.tick_ms        = in_ch.tick_ms;
  assign item.supply_level   = in_ch.supply_level;
  assign item.ignition_level = in_ch.ignition_level;
  assign item.temp_reading   = in_ch.temp_reading;
  assign item.motion_wake    = in_ch.motion_wake;
  assign item.lockup_wake    = in_ch.lockup_wake;
  assign item.watchdog_wake  = in_ch.watchdog_wake;
  assign item.alarm_wake     = in_ch.alarm_wake;
  assign item.host_up        = in_ch.host_up;
  assign item.host_down      = in_ch.host_down;

  // Accept when the result slot is empty or being drained
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign step        = in_ch.valid && in_ready;

  psc_core #(
    .PULSE_MS    (PULSE_MS),
    .RECOVERY_MS (RECOVERY_MS),
    .BACKUP_MS   (BACKUP_MS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.mode_now         = out_r.mode_now;
  assign out_ch.button_pulse     = out_r.button_pulse;
  assign out_ch.shutdown_kind    = out_r.shutdown_kind;
  assign out_ch.led_colour       = out_r.led_colour;
  assign out_ch.power_loss_pulse = out_r.power_loss_pulse;
  assign out_ch.powered_up       = out_r.powered_up;
  assign out_ch.wake_reasons     = out_r.wake_reasons;

endmodule
